// File: src/dcpt_pkg.sv
// Shared types and constants for the dataflow critical path tracker.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package dcpt_pkg;

    localparam int OP_W       = 2;
    localparam int CODE_W     = 5;
    localparam int LAT_W      = 8;
    localparam int REG_W      = 5;
    localparam int INDEX_W    = 16;
    localparam int TIME_W     = 32;
    localparam int PROD_W     = 17;
    localparam int EXT_W      = 9;

    localparam int NUM_REGS_DEF    = 32;
    localparam int NUM_OPCODES_DEF = 32;

    localparam logic [TIME_W-1:0] TIME_MAX      = '1;
    localparam logic [PROD_W-1:0] PRODUCER_NONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_INSTR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [TIME_W-1:0]  finish;
    } writer_t;

endpackage

// File: src/dcpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dcpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dataflow_critical_path_tracker.sv
// Top level of the dataflow critical path tracker: last-writer and latency tables in RAM.
// Depends on dcpt_pkg and dcpt_ram.
//
//   channel | signals                                              | direction
//   in      | in_valid, in_stall, op, opcode, latency_value,       | into block
//           | dest_reg, src_a_reg, src_b_reg                       |
//   out     | out_valid, out_stall, inst_index, start_depth,       | out of block
//           | src_a_producer, src_b_producer, program_depth        |
//
// One item per cycle while in_stall is low; an instruction's result passes the work stage, then the output register.
// Tables are read in the accept cycle; the following stage resolves, writes back and
// forwards the write of the previous cycle, so a dependent item may follow directly.
// Reset clears valid bits of both tables, the index and the program depth at once.
// in_stall rises only when the result register is stalled and the work stage is full.
`timescale 1ns / 1ps

module dataflow_critical_path_tracker #(
    parameter int NUM_REGS    = dcpt_pkg::NUM_REGS_DEF,
    parameter int NUM_OPCODES = dcpt_pkg::NUM_OPCODES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcpt_pkg::OP_W-1:0]           op,
    input  logic [dcpt_pkg::CODE_W-1:0]         opcode,
    input  logic [dcpt_pkg::LAT_W-1:0]          latency_value,
    input  logic [dcpt_pkg::REG_W-1:0]          dest_reg,
    input  logic [dcpt_pkg::REG_W-1:0]          src_a_reg,
    input  logic [dcpt_pkg::REG_W-1:0]          src_b_reg,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dcpt_pkg::INDEX_W-1:0]        inst_index,
    output logic [dcpt_pkg::TIME_W-1:0]         start_depth,
    output logic signed [dcpt_pkg::PROD_W-1:0]  src_a_producer,
    output logic signed [dcpt_pkg::PROD_W-1:0]  src_b_producer,
    output logic [dcpt_pkg::TIME_W-1:0]         program_depth
);

    import dcpt_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int OIDX_W = $clog2(NUM_OPCODES);
    localparam int WR_W   = INDEX_W + TIME_W;

    // work stage
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic [CODE_W-1:0]    s1_code_reg;
    logic [LAT_W-1:0]     s1_lat_in_reg;
    logic [REG_W-1:0]     s1_dest_reg;
    logic [REG_W-1:0]     s1_src_a_reg;
    logic [REG_W-1:0]     s1_src_b_reg;

    logic                 s1_fire;
    logic                 s1_hold;
    logic                 in_fire;

    // program state
    logic [NUM_REGS-1:0]    wvalid_reg;
    logic [NUM_OPCODES-1:0] lvalid_reg;
    logic [INDEX_W-1:0]     next_index_reg;
    logic [TIME_W-1:0]      max_finish_reg;

    // last-write forwarding
    logic                 wr_last_en_reg;
    logic [RIDX_W-1:0]    wr_last_addr_reg;
    writer_t              wr_last_data_reg;
    logic                 lat_last_en_reg;
    logic [OIDX_W-1:0]    lat_last_addr_reg;
    logic [LAT_W-1:0]     lat_last_data_reg;

    // output register
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   out_index_reg;
    logic [TIME_W-1:0]    out_start_reg;
    logic [PROD_W-1:0]    out_prod_a_reg;
    logic [PROD_W-1:0]    out_prod_b_reg;
    logic [TIME_W-1:0]    out_depth_reg;

    // RAM ports
    logic [RIDX_W-1:0]    ra_addr;
    logic [RIDX_W-1:0]    rb_addr;
    logic [OIDX_W-1:0]    rl_addr;
    logic [WR_W-1:0]      ra_data;
    logic [WR_W-1:0]      rb_data;
    logic [LAT_W-1:0]     rl_data;
    logic                 wr_we;
    logic                 lat_we;
    writer_t              wr_wdata;

    // resolve
    logic [EXT_W-1:0]     a_ext;
    logic [EXT_W-1:0]     b_ext;
    logic [EXT_W-1:0]     d_ext;
    logic [EXT_W-1:0]     c_ext;
    logic                 a_ok;
    logic                 b_ok;
    logic                 d_ok;
    logic                 c_ok;
    logic [RIDX_W-1:0]    a_addr;
    logic [RIDX_W-1:0]    b_addr;
    logic [RIDX_W-1:0]    d_addr;
    logic [OIDX_W-1:0]    c_addr;
    logic                 a_has;
    logic                 b_has;
    writer_t              a_w;
    writer_t              b_w;
    logic [TIME_W-1:0]    fin_a;
    logic [TIME_W-1:0]    fin_b;
    logic [TIME_W-1:0]    start_next;
    logic [LAT_W-1:0]     lat;
    logic [TIME_W:0]      sum;
    logic [TIME_W-1:0]    finish;
    logic [TIME_W-1:0]    max_finish_next;
    logic [PROD_W-1:0]    prod_a;
    logic [PROD_W-1:0]    prod_b;

    logic [EXT_W-1:0]     in_a_ext;
    logic [EXT_W-1:0]     in_b_ext;
    logic [EXT_W-1:0]     in_c_ext;

    assign in_fire  = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign s1_hold  = s1_valid_reg && !s1_fire;
    assign in_stall = s1_hold;

    // read addresses: re-read the held item while stalled
    assign in_a_ext = {{(EXT_W-REG_W){1'b0}}, src_a_reg};
    assign in_b_ext = {{(EXT_W-REG_W){1'b0}}, src_b_reg};
    assign in_c_ext = {{(EXT_W-CODE_W){1'b0}}, opcode};

    assign a_ext = {{(EXT_W-REG_W){1'b0}}, s1_src_a_reg};
    assign b_ext = {{(EXT_W-REG_W){1'b0}}, s1_src_b_reg};
    assign d_ext = {{(EXT_W-REG_W){1'b0}}, s1_dest_reg};
    assign c_ext = {{(EXT_W-CODE_W){1'b0}}, s1_code_reg};

    assign a_addr = a_ext[RIDX_W-1:0];
    assign b_addr = b_ext[RIDX_W-1:0];
    assign d_addr = d_ext[RIDX_W-1:0];
    assign c_addr = c_ext[OIDX_W-1:0];

    assign a_ok = a_ext < EXT_W'(NUM_REGS);
    assign b_ok = b_ext < EXT_W'(NUM_REGS);
    assign d_ok = d_ext < EXT_W'(NUM_REGS);
    assign c_ok = c_ext < EXT_W'(NUM_OPCODES);

    assign ra_addr = s1_hold ? a_addr : in_a_ext[RIDX_W-1:0];
    assign rb_addr = s1_hold ? b_addr : in_b_ext[RIDX_W-1:0];
    assign rl_addr = s1_hold ? c_addr : in_c_ext[OIDX_W-1:0];

    dcpt_ram #(.WIDTH(WR_W), .DEPTH(NUM_REGS)) u_writer_a (
        .clk   (clk),
        .we    (wr_we),
        .waddr (d_addr),
        .wdata (wr_wdata),
        .raddr (ra_addr),
        .rdata (ra_data)
    );

    dcpt_ram #(.WIDTH(WR_W), .DEPTH(NUM_REGS)) u_writer_b (
        .clk   (clk),
        .we    (wr_we),
        .waddr (d_addr),
        .wdata (wr_wdata),
        .raddr (rb_addr),
        .rdata (rb_data)
    );

    dcpt_ram #(.WIDTH(LAT_W), .DEPTH(NUM_OPCODES)) u_latency (
        .clk   (clk),
        .we    (lat_we),
        .waddr (c_addr),
        .wdata (s1_lat_in_reg),
        .raddr (rl_addr),
        .rdata (rl_data)
    );

    always_comb
    begin
        a_has = a_ok && wvalid_reg[a_addr];
        b_has = b_ok && wvalid_reg[b_addr];
        a_w   = (wr_last_en_reg && wr_last_addr_reg == a_addr) ? wr_last_data_reg
                                                               : writer_t'(ra_data);
        b_w   = (wr_last_en_reg && wr_last_addr_reg == b_addr) ? wr_last_data_reg
                                                               : writer_t'(rb_data);
        fin_a = a_has ? a_w.finish : '0;
        fin_b = b_has ? b_w.finish : '0;
        start_next = (fin_a > fin_b) ? fin_a : fin_b;
        prod_a = a_has ? {1'b0, a_w.index} : PRODUCER_NONE;
        prod_b = b_has ? {1'b0, b_w.index} : PRODUCER_NONE;

        lat = '0;
        if (c_ok && lvalid_reg[c_addr])
        begin
            lat = (lat_last_en_reg && lat_last_addr_reg == c_addr) ? lat_last_data_reg
                                                                   : rl_data;
        end
        sum    = {1'b0, start_next} + {{(TIME_W+1-LAT_W){1'b0}}, lat};
        finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        max_finish_next = (finish > max_finish_reg) ? finish : max_finish_reg;

        wr_we  = s1_fire && s1_op_reg == OP_INSTR && d_ok;
        lat_we = s1_fire && s1_op_reg == OP_LOAD && c_ok;
        wr_wdata.index  = next_index_reg;
        wr_wdata.finish = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            wvalid_reg      <= '0;
            lvalid_reg      <= '0;
            next_index_reg  <= '0;
            max_finish_reg  <= '0;
            wr_last_en_reg  <= 1'b0;
            lat_last_en_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            wr_last_en_reg  <= wr_we;
            lat_last_en_reg <= lat_we;

            if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                case (s1_op_reg)
                    OP_CLEAR:
                    begin
                        wvalid_reg     <= '0;
                        next_index_reg <= '0;
                        max_finish_reg <= '0;
                    end
                    OP_LOAD:
                    begin
                        if (c_ok)
                        begin
                            lvalid_reg[c_addr] <= 1'b1;
                        end
                    end
                    OP_INSTR:
                    begin
                        if (d_ok)
                        begin
                            wvalid_reg[d_addr] <= 1'b1;
                        end
                        next_index_reg <= next_index_reg + INDEX_W'(1);
                        max_finish_reg <= max_finish_next;
                        out_valid_reg  <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg     <= op_t'(op);
            s1_code_reg   <= opcode;
            s1_lat_in_reg <= latency_value;
            s1_dest_reg   <= dest_reg;
            s1_src_a_reg  <= src_a_reg;
            s1_src_b_reg  <= src_b_reg;
        end

        wr_last_addr_reg  <= d_addr;
        wr_last_data_reg  <= wr_wdata;
        lat_last_addr_reg <= c_addr;
        lat_last_data_reg <= s1_lat_in_reg;

        if (s1_fire && s1_op_reg == OP_INSTR)
        begin
            out_index_reg  <= next_index_reg;
            out_start_reg  <= start_next;
            out_prod_a_reg <= prod_a;
            out_prod_b_reg <= prod_b;
            out_depth_reg  <= max_finish_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign inst_index     = out_index_reg;
    assign start_depth    = out_start_reg;
    assign src_a_producer = out_prod_a_reg;
    assign src_b_producer = out_prod_b_reg;
    assign program_depth  = out_depth_reg;

    a_depth_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_depth_reg >= out_start_reg)
        else $error("program depth below start depth");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_CLEAR) |=>
            (next_index_reg == '0 && max_finish_reg == '0 && wvalid_reg == '0))
        else $error("new program did not clear state");

    a_instr_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg == OP_INSTR) |=> out_valid_reg)
        else $error("instruction result missing");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && s1_valid_reg))
        else $error("input stalled with free stage");

endmodule

// File: test/tb_dataflow_critical_path_tracker.sv
// Testbench for dataflow_critical_path_tracker: random instruction traces with directed corners,
// checked against an in-bench depth tracker. Depends on dcpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_dataflow_critical_path_tracker;
    import dcpt_pkg::*;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] opcode;
        logic [LAT_W-1:0]  lat;
        logic [REG_W-1:0]  dest;
        logic [REG_W-1:0]  src_a;
        logic [REG_W-1:0]  src_b;
    } trace_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [TIME_W-1:0]  start;
        logic [PROD_W-1:0]  prod_a;
        logic [PROD_W-1:0]  prod_b;
        logic [TIME_W-1:0]  depth;
    } depth_result_t;

    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 120;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op = '0;
    logic [CODE_W-1:0]        opcode = '0;
    logic [LAT_W-1:0]         latency_value = '0;
    logic [REG_W-1:0]         dest_reg = '0;
    logic [REG_W-1:0]         src_a_reg = '0;
    logic [REG_W-1:0]         src_b_reg = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [INDEX_W-1:0]       inst_index;
    logic [TIME_W-1:0]        start_depth;
    logic signed [PROD_W-1:0] src_a_producer;
    logic signed [PROD_W-1:0] src_b_producer;
    logic [TIME_W-1:0]        program_depth;

    trace_item_t   trace_feed[$];
    depth_result_t pending_depths[$];

    logic [LAT_W-1:0]   lat_table [NUM_OPCODES_DEF];
    logic [NUM_REGS_DEF-1:0] reg_written = '0;
    logic [INDEX_W-1:0] last_writer [NUM_REGS_DEF];
    logic [TIME_W-1:0]  reg_finish [NUM_REGS_DEF];
    logic [INDEX_W-1:0] trace_index = '0;
    logic [TIME_W-1:0]  deepest = '0;

    int  work_items = 0;
    int  items_accepted = 0;
    int  calm_mark = 32'h7fff_ffff;
    int  mismatches = 0;
    bit  item_taken = 1'b0;
    bit  backlog_hold = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    dataflow_critical_path_tracker u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .opcode         (opcode),
        .latency_value  (latency_value),
        .dest_reg       (dest_reg),
        .src_a_reg      (src_a_reg),
        .src_b_reg      (src_b_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .inst_index     (inst_index),
        .start_depth    (start_depth),
        .src_a_producer (src_a_producer),
        .src_b_producer (src_b_producer),
        .program_depth  (program_depth)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void add_item(input op_t kind, input int code, input int lat,
                                     input int dest, input int a, input int b);
        trace_item_t it;
        it.op     = kind;
        it.opcode = code[CODE_W-1:0];
        it.lat    = lat[LAT_W-1:0];
        it.dest   = dest[REG_W-1:0];
        it.src_a  = a[REG_W-1:0];
        it.src_b  = b[REG_W-1:0];
        trace_feed.push_back(it);
        if (kind != OP_NONE)
            work_items++;
    endfunction

    function automatic int pick_latency();
        int roll;
        roll = $urandom_range(0, 3);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_reg(input int pool);
        if ($urandom_range(0, 3) != 0)
            return $urandom_range(0, pool);
        return $urandom_range(0, 31);
    endfunction

    function automatic void add_program(input bool_fresh);
        int pool;
        int roll;
        if (bool_fresh)
            add_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 255),
                     $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        repeat ($urandom_range(0, 4))
            add_item(OP_LOAD, $urandom_range(0, 31), pick_latency(),
                     $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        pool = $urandom_range(1, 31);
        repeat ($urandom_range(4, 40))
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
                add_item(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 255),
                         $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
            else if (roll == 1)
                add_item(OP_LOAD, $urandom_range(0, 31), pick_latency(),
                         $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
            else
                add_item(OP_INSTR, $urandom_range(0, 31), $urandom_range(0, 255),
                         pick_reg(pool), pick_reg(pool), pick_reg(pool));
        end
    endfunction

    function automatic bit apply_trace_item(input trace_item_t it, output depth_result_t res);
        logic [TIME_W-1:0] start;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] finish;
        res = '0;
        start = '0;
        case (it.op)
            OP_CLEAR:
            begin
                reg_written = '0;
                trace_index = '0;
                deepest = '0;
                return 1'b0;
            end
            OP_LOAD:
            begin
                lat_table[it.opcode] = it.lat;
                return 1'b0;
            end
            OP_INSTR:
            begin
                res.prod_a = PRODUCER_NONE;
                res.prod_b = PRODUCER_NONE;
                if (reg_written[it.src_a])
                begin
                    res.prod_a = {1'b0, last_writer[it.src_a]};
                    if (reg_finish[it.src_a] > start)
                        start = reg_finish[it.src_a];
                end
                if (reg_written[it.src_b])
                begin
                    res.prod_b = {1'b0, last_writer[it.src_b]};
                    if (reg_finish[it.src_b] > start)
                        start = reg_finish[it.src_b];
                end
                sum = {1'b0, start} + lat_table[it.opcode];
                finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                if (finish > deepest)
                    deepest = finish;
                reg_written[it.dest] = 1'b1;
                last_writer[it.dest] = trace_index;
                reg_finish[it.dest] = finish;
                res.index = trace_index;
                res.start = start;
                res.depth = deepest;
                trace_index = trace_index + 1'b1;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void flag_failure(input string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endfunction

    always @(posedge clk)
    begin
        trace_item_t   it;
        depth_result_t want;
        depth_result_t got;
        if (rst_n)
        begin
            item_taken = in_valid && !in_stall;
            if (item_taken)
            begin
                it = trace_feed.pop_front();
                items_accepted++;
                if (apply_trace_item(it, want))
                    pending_depths.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = {inst_index, start_depth, src_a_producer, src_b_producer, program_depth};
                if (pending_depths.size() == 0)
                    flag_failure($sformatf("unexpected result: index %0d start %0d",
                                           inst_index, start_depth));
                else
                begin
                    want = pending_depths.pop_front();
                    if (got !== want)
                        flag_failure($sformatf(
                            {"mismatch: index %0d/%0d start %0d/%0d prod_a %0d/%0d ",
                             "prod_b %0d/%0d depth %0d/%0d (expected/actual)"},
                            want.index, got.index, want.start, got.start,
                            $signed(want.prod_a), $signed(got.prod_a),
                            $signed(want.prod_b), $signed(got.prod_b),
                            want.depth, got.depth));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !item_taken)
        begin
            // hold the offered item
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (trace_feed.size() == 0)
            in_valid <= 1'b0;
        else if (items_accepted < calm_mark && !backlog_hold && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap_left = $urandom_range(0, 5);
        end
        else
        begin
            op            <= trace_feed[0].op;
            opcode        <= trace_feed[0].opcode;
            latency_value <= trace_feed[0].lat;
            dest_reg      <= trace_feed[0].dest;
            src_a_reg     <= trace_feed[0].src_a;
            src_b_reg     <= trace_feed[0].src_b;
            in_valid      <= 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (!hold_done && items_accepted >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (items_accepted < calm_mark && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 5);
            end
            else
                out_stall <= 1'b0;
            backlog_hold = (hold_left > 0);
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_OPCODES_DEF; i++)
            lat_table[i] = '0;

        add_item(OP_INSTR, 0, 0, 0, 0, 0);
        add_item(OP_INSTR, 31, 255, 31, 31, 31);
        add_item(OP_LOAD, 31, 255, 0, 0, 0);
        add_item(OP_LOAD, 0, 0, 31, 31, 31);
        add_item(OP_LOAD, 5, 1, 0, 0, 0);
        add_item(OP_LOAD, 10, 200, 0, 0, 0);
        add_item(OP_LOAD, 17, 128, 0, 0, 0);
        add_item(OP_NONE, 31, 255, 31, 31, 31);
        add_item(OP_INSTR, 31, 0, 1, 31, 0);
        add_item(OP_INSTR, 5, 0, 2, 1, 1);
        add_item(OP_INSTR, 10, 0, 2, 2, 1);
        add_item(OP_INSTR, 0, 0, 31, 2, 31);
        add_item(OP_CLEAR, 0, 0, 0, 0, 0);
        add_item(OP_INSTR, 17, 0, 0, 2, 31);
        add_item(OP_INSTR, 31, 0, 30, 0, 0);
        add_item(OP_LOAD, 31, 0, 0, 0, 0);
        add_item(OP_INSTR, 31, 0, 29, 30, 0);
        add_item(OP_NONE, 0, 0, 0, 0, 0);
        add_item(OP_CLEAR, 31, 255, 31, 31, 31);
        add_item(OP_INSTR, 0, 0, 0, 0, 0);

        while (work_items < 1450)
            add_program($urandom_range(0, 3) != 0);

        calm_mark = trace_feed.size();
        while (trace_feed.size() < calm_mark + 150)
            add_program(1'b1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (trace_feed.size() != 0)
            @(posedge clk);
        while (pending_depths.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
